// ===== hdl/bse_pkg.sv =====
// Shared types, constants and helpers for the backslash escape encoder.
// Used by bse_regs, bse_encode, bse_emit and backslash_escape_encoder.
// No dependencies.
`default_nettype none

package bse_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BUFFER_SIZE = 3'd0;
  localparam logic [2:0] REG_MASK_0      = 3'd1;
  localparam logic [2:0] REG_MASK_1      = 3'd2;
  localparam logic [2:0] REG_MASK_2      = 3'd3;
  localparam logic [2:0] REG_MASK_3      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] BUFFER_SIZE_RST = 16'd256;
  localparam logic [63:0] MASK_0_RST      = 64'h0000_0084_0000_2600;
  localparam logic [63:0] MASK_1_RST      = 64'h0000_0000_1000_0000;
  localparam logic [63:0] MASK_2_RST      = 64'h0;
  localparam logic [63:0] MASK_3_RST      = 64'h0;

  // Character codes.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Configuration as seen by the encoder.
  typedef struct packed {
    logic [15:0]  buffer_size;
    logic [255:0] mask;
    logic         size_wr;
  } bse_cfg_t;

  // Output job caused by one input byte: up to four bytes and a terminator.
  typedef struct packed {
    logic [3:0][7:0] seq;
    logic [2:0]      nbytes;
    logic            term;
    logic            trunc;
  } bse_job_t;

  // Room for the string itself; a zero buffer size behaves like one.
  function automatic logic [15:0] bse_init_room(input logic [15:0] size);
    bse_init_room = (size == 16'd0) ? 16'd0 : size - 16'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bse_regs.sv =====
// Configuration registers of the backslash escape encoder.
// Depends on bse_pkg.
`default_nettype none

module bse_regs
  import bse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output bse_cfg_t         cfg
);

  logic [15:0] buffer_size_r;
  logic [63:0] mask0_r;
  logic [63:0] mask1_r;
  logic [63:0] mask2_r;
  logic [63:0] mask3_r;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= BUFFER_SIZE_RST;
      mask0_r       <= MASK_0_RST;
      mask1_r       <= MASK_1_RST;
      mask2_r       <= MASK_2_RST;
      mask3_r       <= MASK_3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_SIZE: buffer_size_r <= cfg_wdata[15:0];
        REG_MASK_0:      mask0_r       <= cfg_wdata;
        REG_MASK_1:      mask1_r       <= cfg_wdata;
        REG_MASK_2:      mask2_r       <= cfg_wdata;
        REG_MASK_3:      mask3_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.buffer_size = buffer_size_r;
  assign cfg.mask        = {mask3_r, mask2_r, mask1_r, mask0_r};
  assign cfg.size_wr     = cfg_we && (cfg_index == REG_BUFFER_SIZE);

endmodule

`default_nettype wire

// ===== hdl/bse_encode.sv =====
// Escape encoder and string budget state of the backslash escape encoder.
// Turns one source byte into an output job. Depends on bse_pkg.
`default_nettype none

module bse_encode
  import bse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bse_cfg_t   cfg,
  input  wire logic       in_acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output bse_job_t        job
);

  logic [15:0] room_r;
  logic        stopped_r;
  logic        restart_r;

  logic [15:0]     room_eff;
  logic            stop_eff;
  logic            masked;
  logic [3:0][7:0] seq;
  logic [2:0]      len;
  logic [2:0]      need;
  logic            fits;
  logic [15:0]     room_nxt;
  logic            stopped_nxt;
  logic            restart_nxt;

  // Escape form of the byte and the room it needs.
  always_comb begin
    masked = cfg.mask[in_byte];
    seq    = '0;
    len    = 3'd1;
    need   = 3'd1;
    if (!masked) begin
      seq[0] = in_byte;
    end else begin
      seq[0] = CH_BSLASH;
      len    = 3'd2;
      need   = 3'd2;
      case (in_byte)
        CH_TAB:    seq[1] = CH_LOW_T;
        CH_NL:     seq[1] = CH_LOW_N;
        CH_CR:     seq[1] = CH_LOW_R;
        CH_DQUOTE: seq[1] = in_byte;
        CH_SQUOTE: seq[1] = in_byte;
        CH_BSLASH: seq[1] = in_byte;
        default: begin
          seq[1] = CH_DIGIT0 + {6'd0, in_byte[7:6]};
          seq[2] = CH_DIGIT0 + {5'd0, in_byte[5:3]};
          seq[3] = CH_DIGIT0 + {5'd0, in_byte[2:0]};
          len    = 3'd4;
          need   = 3'd5;
        end
      endcase
    end
  end

  // Budget check, job build and next string state.
  always_comb begin
    room_eff    = restart_r ? bse_init_room(cfg.buffer_size) : room_r;
    stop_eff    = restart_r ? 1'b0 : stopped_r;
    fits        = room_eff >= {13'd0, need};
    job         = '0;
    room_nxt    = room_eff;
    stopped_nxt = stop_eff;
    restart_nxt = restart_r;
    if (in_byte == CH_NUL) begin
      // A zero byte ends the string at once.
      job.term    = 1'b1;
      job.trunc   = stop_eff;
      restart_nxt = 1'b1;
    end else begin
      restart_nxt = 1'b0;
      if (!stop_eff) begin
        if (fits) begin
          job.seq    = seq;
          job.nbytes = len;
          room_nxt   = room_eff - {13'd0, len};
        end else begin
          stopped_nxt = 1'b1;
        end
      end
      if (end_of_string) begin
        job.term    = 1'b1;
        job.trunc   = stopped_nxt;
        restart_nxt = 1'b1;
      end
    end
  end

  // String state; a buffer size write abandons the current string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
      stopped_r <= 1'b0;
    end else if (cfg.size_wr) begin
      restart_r <= 1'b1;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      restart_r <= restart_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      room_r <= room_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bse_emit.sv =====
// Output sequencer of the backslash escape encoder, using bse_pkg: holds one
// job and sends its bytes and terminator one transfer per cycle unless stalled.
`default_nettype none

module bse_emit
  import bse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire bse_job_t   job_in,
  output logic            free,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_byte,
  output logic            is_terminator,
  output logic            truncated,
  output logic            last_of_run
);

  logic       valid_r;
  bse_job_t   job_r;
  logic [2:0] idx_r;
  logic [2:0] total;
  logic       in_seq;
  logic       out_xfer;

  assign total    = job_r.nbytes + {2'd0, job_r.term};
  assign in_seq   = idx_r < job_r.nbytes;
  assign out_xfer = valid_r && out_tready;

  assign out_tvalid    = valid_r;
  assign out_byte      = in_seq ? job_r.seq[idx_r[1:0]] : CH_NUL;
  assign is_terminator = !in_seq;
  assign truncated     = !in_seq && job_r.trunc;
  assign last_of_run   = idx_r == (total - 3'd1);

  // A new job may enter while the last transfer of the current one is taken.
  assign free = !valid_r || (out_xfer && last_of_run);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 3'd0;
    end else if (out_xfer) begin
      if (last_of_run) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
  end

  // A held job always has something left to send.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < total))
    else $error("emit index past end of job");

  // Loading only happens when the holding register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("job loaded over a pending one");

  // A transfer that is not the last advances to the next byte.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !last_of_run) |=> (valid_r && idx_r == $past(idx_r) + 3'd1))
    else $error("emit index did not advance");

  // Only the terminator carries the truncated flag.
  a_trunc_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && truncated) |-> is_terminator)
    else $error("truncated flag outside terminator");

endmodule

`default_nettype wire

// ===== hdl/backslash_escape_encoder.sv =====
// Top level of the backslash escape encoder.
// Depends on bse_pkg, bse_regs, bse_encode and bse_emit.
//
// Usage: source string bytes arrive on the in_ stream, one byte per transfer,
// with in_tlast marking the final byte; a zero byte also ends the string.
// The escaped text leaves on the out_ stream, one byte per transfer, followed
// by a zero terminator flagged in out_tuser. out_tlast marks the last result
// caused by each input byte. Bytes that do not fit the buffer budget are
// dropped for the rest of the string and the terminator reports truncation.
// The first result of a byte is presented the cycle after its input transfer.
// Plain bytes are taken one input byte per cycle while the receiver is ready;
// a byte with several results holds the input until the single output port
// has sent them all (escape pairs 2, octal escapes 4, plus 1 for a terminator).
// The output job register lets the next byte enter in the cycle the last
// result of the previous one is taken. When the receiver stalls, the held
// result stays on the port and in_tready drops.
// Reset (rst_n low, synchronous) empties the output, loads the default
// register values and starts a fresh string. Configuration writes are
// taken at any time but must only be made while the block is idle.
`default_nettype none

module backslash_escape_encoder
  import bse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_string
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic [1:0]       out_tuser,  // [0] is_terminator, [1] truncated
  output logic             out_tlast,  // last_of_run
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  bse_cfg_t cfg;
  bse_job_t job;
  logic     in_acc;
  logic     load;
  logic     free;
  logic     is_terminator;
  logic     truncated;

  assign in_tready = free;
  assign in_acc    = in_tvalid && in_tready;
  assign load      = in_acc && ((job.nbytes != 3'd0) || job.term);

  bse_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bse_encode u_encode (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_acc        (in_acc),
    .in_byte       (in_tdata),
    .end_of_string (in_tlast),
    .job           (job)
  );

  bse_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .job_in        (job),
    .free          (free),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_byte      (out_tdata),
    .is_terminator (is_terminator),
    .truncated     (truncated),
    .last_of_run   (out_tlast)
  );

  assign out_tuser = {truncated, is_terminator};

endmodule

`default_nettype wire
